[sv/lprl_pkg.sv]
// Package for the longest-prefix route lookup engine: request and response beat types,
// operation codes and controller states.
// No dependencies.
`default_nettype none

package lprl_pkg;

    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef struct packed {
        t_op         operation;
        logic [5:0]  entry_index;
        logic [31:0] route_prefix;
        logic [31:0] route_mask;
        logic [31:0] gateway_addr;
        logic [3:0]  egress_port;
        logic [31:0] dest_addr;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] next_hop;
        logic [3:0]  out_port;
    } t_rsp;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

endpackage

`default_nettype wire

[sv/longest_prefix_route_lookup.sv]
// Longest-prefix route lookup: a route table memory and the controller that scans it.
// Depends on lprl_pkg for the beat types, operation codes and states.
// A write beat goes straight into the table on acceptance. A lookup beat scans every entry,
// through the single read port that returns one entry per cycle, then passes S_DRAIN and strobes.
// A new beat may be accepted in the cycle that carries the result strobe.
// After reset a clearing pass marks every entry invalid; busy is high during it.
`default_nettype none

module longest_prefix_route_lookup #(
    parameter int TABLE_ENTRIES = 64,
    parameter int PORT_BITS     = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire lprl_pkg::t_req i_req,
    output logic               busy,
    output logic               o_valid,
    output lprl_pkg::t_rsp     o_rsp
);
    import lprl_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int WORD_W = 1 + 32 + 32 + 32 + PORT_BITS;

    logic [WORD_W-1:0] r_mem [TABLE_ENTRIES];
    logic [WORD_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic              r_rd_vld;
    logic              r_strobe, n_strobe;
    logic [31:0]       r_dest;
    logic              r_found;
    logic [31:0]       r_best_mask;
    logic [31:0]       r_best_hop;
    logic [PORT_BITS-1:0] r_best_port;

    logic              accept;
    logic              lookup_go;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W+5:0]  idx_ext;
    logic [PORT_BITS+3:0] port_in_ext;
    logic [PORT_BITS+3:0] port_out_ext;

    logic              e_valid;
    logic [31:0]       e_prefix;
    logic [31:0]       e_mask;
    logic [31:0]       e_hop;
    logic [PORT_BITS-1:0] e_port;
    logic              take;

    assign accept      = start && !busy;
    assign lookup_go   = accept && (i_req.operation == OP_LOOKUP);
    assign idx_ext     = {{IDX_W{1'b0}}, i_req.entry_index};
    assign port_in_ext = {{PORT_BITS{1'b0}}, i_req.egress_port};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_cnt;
        wr_data  = '0;
        rd_en    = 1'b0;
        busy     = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy = 1'b0;
                if (start && (i_req.operation == OP_WRITE)) begin
                    wr_en   = (32'(i_req.entry_index) < TABLE_ENTRIES);
                    wr_addr = idx_ext[IDX_W-1:0];
                    wr_data = {1'b1, i_req.route_prefix, i_req.route_mask,
                               i_req.gateway_addr, port_in_ext[PORT_BITS-1:0]};
                end
                if (start && (i_req.operation == OP_LOOKUP)) begin
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                rd_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= rd_en;
            r_strobe <= n_strobe;
            if (lookup_go) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    assign {e_valid, e_prefix, e_mask, e_hop, e_port} = r_rd_data;
    assign take = r_rd_vld && e_valid && ((r_dest & e_mask) == e_prefix)
                  && (!r_found || (e_mask > r_best_mask));

    always_ff @(posedge i_clk) begin
        if (lookup_go) begin
            r_dest      <= i_req.dest_addr;
            r_best_mask <= '0;
            r_best_hop  <= '0;
            r_best_port <= '0;
        end else if (take) begin
            r_best_mask <= e_mask;
            r_best_hop  <= e_hop;
            r_best_port <= e_port;
        end
    end

    assign port_out_ext   = {4'b0000, r_best_port};
    assign o_valid        = r_strobe;
    assign o_rsp.hit      = r_found;
    assign o_rsp.next_hop = r_best_hop;
    assign o_rsp.out_port = port_out_ext[3:0];

    a_strobe_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_DRAIN))
        else $error("result strobe without a finished scan");

    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ($past(r_state) == S_SCAN))
        else $error("entry read returned outside a scan");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.hit) |-> ((o_rsp.next_hop == '0) && (o_rsp.out_port == '0)))
        else $error("miss result carries a non-zero route");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) || (r_state == S_DRAIN)) |-> !wr_en)
        else $error("table write during a scan");

endmodule

`default_nettype wire

[dv/longest_prefix_route_lookup_test.sv]
// Self-checking testbench for longest_prefix_route_lookup: route writes and lookups
// are driven, and each lookup answer is checked against a behavioural route table.
// Depends on lprl_pkg and the longest_prefix_route_lookup RTL.
`default_nettype none

module longest_prefix_route_lookup_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lprl_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int PORT_BITS     = 4;
    localparam logic [3:0] PORT_MASK = 4'((1 << PORT_BITS) - 1);
    localparam int RANDOM_BEATS  = 1230;
    localparam int CALM_TAIL     = 150;
    localparam int STALL_LIMIT   = 4000;

    typedef struct {
        logic drain_first;
        t_req req;
    } t_pending_beat;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    t_pending_beat pending_beats[$];
    t_rsp          expected_routes[$];

    logic [31:0] route_prefix_tbl [TABLE_ENTRIES];
    logic [31:0] route_mask_tbl   [TABLE_ENTRIES];
    logic [31:0] route_hop_tbl    [TABLE_ENTRIES];
    logic [3:0]  route_port_tbl   [TABLE_ENTRIES];
    logic        route_valid_tbl  [TABLE_ENTRIES];

    logic [31:0] plan_prefix [TABLE_ENTRIES];
    logic [31:0] plan_mask   [TABLE_ENTRIES];
    logic        plan_used   [TABLE_ENTRIES];

    int error_count  = 0;
    int quiet_left   = 0;
    int stall_cycles = 0;

    longest_prefix_route_lookup #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .PORT_BITS    (PORT_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void resolve_route(input t_req beat);
        t_rsp        best;
        logic        found;
        logic [31:0] best_mask;
        found     = 1'b0;
        best_mask = '0;
        best      = '0;
        if (beat.operation == OP_WRITE) begin
            if (int'(beat.entry_index) < TABLE_ENTRIES) begin
                route_prefix_tbl[beat.entry_index] = beat.route_prefix;
                route_mask_tbl[beat.entry_index]   = beat.route_mask;
                route_hop_tbl[beat.entry_index]    = beat.gateway_addr;
                route_port_tbl[beat.entry_index]   = beat.egress_port & PORT_MASK;
                route_valid_tbl[beat.entry_index]  = 1'b1;
            end
            return;
        end
        for (int n = 0; n < TABLE_ENTRIES; n++) begin
            if (route_valid_tbl[n] && (beat.dest_addr & route_mask_tbl[n]) == route_prefix_tbl[n]
                    && (!found || route_mask_tbl[n] > best_mask)) begin
                found         = 1'b1;
                best_mask     = route_mask_tbl[n];
                best.hit      = 1'b1;
                best.next_hop = route_hop_tbl[n];
                best.out_port = route_port_tbl[n];
            end
        end
        expected_routes.push_back(best);
    endfunction

    function automatic void queue_write(input logic [5:0] idx, input logic [31:0] prefix,
                                        input logic [31:0] mask, input logic [31:0] hop,
                                        input logic [3:0] port, input logic drain);
        t_pending_beat beat;
        beat.drain_first      = drain;
        beat.req.operation    = OP_WRITE;
        beat.req.entry_index  = idx;
        beat.req.route_prefix = prefix;
        beat.req.route_mask   = mask;
        beat.req.gateway_addr = hop;
        beat.req.egress_port  = port;
        beat.req.dest_addr    = $urandom;
        pending_beats.push_back(beat);
        plan_prefix[idx] = prefix;
        plan_mask[idx]   = mask;
        plan_used[idx]   = 1'b1;
    endfunction

    function automatic void queue_lookup(input logic [31:0] dest, input logic drain);
        t_pending_beat beat;
        beat.drain_first      = drain;
        beat.req.operation    = OP_LOOKUP;
        beat.req.entry_index  = 6'($urandom_range(0, 63));
        beat.req.route_prefix = $urandom;
        beat.req.route_mask   = $urandom;
        beat.req.gateway_addr = $urandom;
        beat.req.egress_port  = 4'($urandom_range(0, 15));
        beat.req.dest_addr    = dest;
        pending_beats.push_back(beat);
    endfunction

    initial begin
        logic [31:0] net_base [4];
        logic [31:0] mask;
        logic [31:0] prefix;
        int          len;
        int          slot;
        logic        drain;

        for (int n = 0; n < TABLE_ENTRIES; n++) begin
            route_valid_tbl[n] = 1'b0;
            plan_used[n]       = 1'b0;
        end
        for (int n = 0; n < 4; n++) begin
            net_base[n] = $urandom;
        end

        queue_lookup(32'h0000_0000, 1'b0);
        queue_lookup(32'hFFFF_FFFF, 1'b0);
        queue_write(6'd0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15, 1'b0);
        queue_lookup(32'h1234_5678, 1'b0);
        queue_write(6'd63, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_0001, 4'd3, 1'b0);
        queue_lookup(32'hC0A8_01FF, 1'b0);
        queue_write(6'd5, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0A00_0005, 4'd1, 1'b0);
        queue_lookup(32'hC0A8_0201, 1'b0);
        queue_write(6'd62, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_003E, 4'd7, 1'b0);
        queue_lookup(32'hC0A8_0101, 1'b0);
        queue_write(6'd10, 32'h0000_00F0, 32'h0000_000F, 32'h5555_5555, 4'd9, 1'b0);
        queue_lookup(32'h0000_00F0, 1'b0);
        queue_write(6'd11, 32'hA0B0_C0D0, 32'hF0F0_F0F0, 32'hAAAA_AAAA, 4'd8, 1'b0);
        queue_lookup(32'hA5B5_C5D5, 1'b0);
        queue_write(6'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0, 1'b0);
        queue_lookup(32'hFFFF_FFFF, 1'b0);
        queue_write(6'd0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0001, 4'd4, 1'b1);
        queue_lookup(32'h1234_5678, 1'b0);
        queue_lookup(32'h0000_0001, 1'b0);

        for (int k = 0; k < RANDOM_BEATS; k++) begin
            drain = (k % 150 == 149);
            if ($urandom_range(0, 99) < 35) begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(8, 28);
                mask = (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - len);
                if ($urandom_range(0, 9) == 0) begin
                    mask = $urandom;
                end
                prefix = ($urandom_range(0, 3) != 0) ? net_base[$urandom_range(0, 3)] : $urandom;
                prefix = ($urandom_range(0, 11) == 0) ? $urandom : (prefix & mask);
                queue_write(6'($urandom_range(0, 63)), prefix, mask, $urandom,
                            4'($urandom_range(0, 15)), drain);
            end else if ($urandom_range(0, 9) < 7) begin
                do begin
                    slot = $urandom_range(0, TABLE_ENTRIES - 1);
                end while (!plan_used[slot]);
                queue_lookup((plan_prefix[slot] & plan_mask[slot]) | ($urandom & ~plan_mask[slot]),
                             drain);
            end else begin
                queue_lookup($urandom, drain);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || expected_routes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("longest_prefix_route_lookup_test: done, clean");
        end else begin
            $display("longest_prefix_route_lookup_test: done, errors");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        logic launch;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                resolve_route(pending_beats[0].req);
                void'(pending_beats.pop_front());
            end
            if (quiet_left > 0) begin
                quiet_left--;
            end else if (pending_beats.size() > CALM_TAIL && $urandom_range(0, 24) == 0) begin
                quiet_left = $urandom_range(1, 18);
            end
            if (pending_beats.size() != 0 && pending_beats[0].drain_first
                    && expected_routes.size() == 0) begin
                pending_beats[0].drain_first = 1'b0;
            end
            launch = quiet_left == 0 && pending_beats.size() != 0 && !pending_beats[0].drain_first;
            start <= launch;
            if (launch) begin
                i_req <= pending_beats[0].req;
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_routes.size() == 0) begin
                $display("%0t: result beat with none expected, actual %p", $time, o_rsp);
                error_count++;
            end else begin
                want = expected_routes.pop_front();
                if (o_rsp.hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, o_rsp.hit);
                    error_count++;
                end
                if (o_rsp.next_hop !== want.next_hop) begin
                    $display("%0t: next_hop expected %08h actual %08h", $time, want.next_hop,
                             o_rsp.next_hop);
                    error_count++;
                end
                if (o_rsp.out_port !== want.out_port) begin
                    $display("%0t: out_port expected %0d actual %0d", $time, want.out_port,
                             o_rsp.out_port);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("longest_prefix_route_lookup_test: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

`default_nettype wire
